// ===== sv/afcp_pkg.sv =====
// Package: types, constants and CORDIC table for the chamber pressure pipeline.
`timescale 1ns / 1ps
`default_nettype none
package afcp_pkg;

  localparam int ATAN_LEN = 24;
  localparam int ZW = 35;                        // Q.30 angle width with sign
  localparam int XW = 34;                        // CORDIC x/y width
  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [17:0]   SQRT3_Q16   = 18'sd113512;
  localparam logic [2:0] CFG_BEND_STIFF = 3'd0;
  localparam logic [2:0] CFG_AXIAL_STIFF = 3'd1;
  localparam logic [2:0] CFG_REST_LEN = 3'd2;
  localparam logic [2:0] CFG_AXIAL_FORCE = 3'd3;
  localparam logic [2:0] CFG_TORQUE_A = 3'd4;
  localparam logic [2:0] CFG_TORQUE_B = 3'd5;
  localparam logic [2:0] CFG_OFFSET = 3'd6;

  typedef struct packed {
    logic [15:0]        bend_stiffness;
    logic [15:0]        axial_stiffness;
    logic [15:0]        rest_length;
    logic signed [15:0] axial_force;
    logic signed [15:0] torque_a;
    logic signed [15:0] torque_b;
    logic signed [15:0] pressure_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 35'sd843314856;  5'd1: r = 35'sd497837829;
      5'd2: r = 35'sd263043836;  5'd3: r = 35'sd133525158;
      5'd4: r = 35'sd67021686;   5'd5: r = 35'sd33543515;
      5'd6: r = 35'sd16775850;   5'd7: r = 35'sd8388437;
      5'd8: r = 35'sd4194282;    5'd9: r = 35'sd2097149;
      5'd10: r = 35'sd1048575;   5'd11: r = 35'sd524287;
      5'd12: r = 35'sd262143;    5'd13: r = 35'sd131071;
      5'd14: r = 35'sd65535;     5'd15: r = 35'sd32767;
      5'd16: r = 35'sd16383;     5'd17: r = 35'sd8191;
      5'd18: r = 35'sd4095;      5'd19: r = 35'sd2047;
      5'd20: r = 35'sd1023;      5'd21: r = 35'sd511;
      5'd22: r = 35'sd255;       5'd23: r = 35'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/afcp_if.sv =====
// Valid/ready stream interfaces for setpoints and chamber pressures.
`timescale 1ns / 1ps
`default_nettype none
interface afcp_setpoint_if;
  logic              valid;
  logic              ready;
  logic [3:0]        segment_index;
  logic signed [15:0] bend_angle;
  logic signed [15:0] bend_direction;
  logic [15:0]       seg_length;
  modport source (output valid, segment_index, bend_angle, bend_direction, seg_length,
                  input ready);
  modport sink (input valid, segment_index, bend_angle, bend_direction, seg_length,
                output ready);
endinterface

interface afcp_pressure_if;
  logic              valid;
  logic              ready;
  logic [3:0]        segment_tag;
  logic signed [31:0] pressure_0;
  logic signed [31:0] pressure_1;
  logic signed [31:0] pressure_2;
  logic signed [31:0] pressure_3;
  logic signed [31:0] pressure_4;
  logic signed [31:0] pressure_5;
  modport source (output valid, segment_tag, pressure_0, pressure_1, pressure_2,
                  pressure_3, pressure_4, pressure_5, input ready);
  modport sink (input valid, segment_tag, pressure_0, pressure_1, pressure_2,
                pressure_3, pressure_4, pressure_5, output ready);
endinterface
`default_nettype wire

// ===== sv/afcp_cordic_stage.sv =====
// One registered CORDIC rotation step with its side payload.
`timescale 1ns / 1ps
`default_nettype none
module afcp_cordic_stage
  import afcp_pkg::*;
#(
  parameter int STEP = 0,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire rot_t          in_rot,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output rot_t               out_rot,
  output logic [PW-1:0]      out_pay
);
  rot_t rot_next;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] a;

  always_comb begin
    xs = in_rot.x >>> STEP;
    ys = in_rot.y >>> STEP;
    a  = atan_q30(5'(STEP));
    if (!in_rot.z[ZW-1]) begin
      rot_next.x = in_rot.x - ys;
      rot_next.y = in_rot.y + xs;
      rot_next.z = in_rot.z - a;
    end else begin
      rot_next.x = in_rot.x + ys;
      rot_next.y = in_rot.y - xs;
      rot_next.z = in_rot.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rot <= rot_next;
      out_pay <= in_pay;
    end
  end
endmodule
`default_nettype wire

// ===== sv/afcp_sincos.sv =====
// Pipelined sin/cos: range reduction, fold, and a chain of CORDIC stages.
`timescale 1ns / 1ps
`default_nettype none
module afcp_sincos
  import afcp_pkg::*;
#(
  parameter int ITER = 16,
  parameter int PW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] beta,
  input  wire logic [PW-1:0]      in_pay,
  output logic                    out_valid,
  output logic signed [XW-1:0]    cos_q30,
  output logic signed [XW-1:0]    sin_q30,
  output logic [PW-1:0]           out_pay
);
  localparam int N = (ITER > ATAN_LEN) ? ATAN_LEN : ITER;

  // reduction stage: z, negate flag
  logic signed [ZW-1:0] z0, z1;
  rot_t                 r0;
  logic                 v0, neg0;
  logic [PW-1:0]        p0;
  logic                 neg_q;

  always_comb begin
    z0 = ZW'(beta) <<< 18;
    // |beta| < 8 < 3*pi, one wrap suffices
    if (z0 > PI_Q30) z0 = z0 - TWO_PI_Q30;
    else if (z0 < -PI_Q30) z0 = z0 + TWO_PI_Q30;
    neg0 = 1'b0;
    z1 = z0;
    if (z0 > HALF_PI_Q30) begin
      z1 = z0 - PI_Q30;
      neg0 = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z1 = z0 + PI_Q30;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      r0.x <= GAIN_Q30;
      r0.y <= '0;
      r0.z <= z1;
      p0 <= {in_pay[PW-1:1], neg0};
    end
  end

  rot_t          rot [N+1];
  logic          vv  [N+1];
  logic [PW-1:0] pp  [N+1];
  assign rot[0] = r0;
  assign vv[0]  = v0;
  assign pp[0]  = p0;

  for (genvar g = 0; g < N; g++) begin : g_stage
    afcp_cordic_stage #(.STEP(g), .PW(PW)) u_stage (
      .clk, .rst, .en,
      .in_valid(vv[g]), .in_rot(rot[g]), .in_pay(pp[g]),
      .out_valid(vv[g+1]), .out_rot(rot[g+1]), .out_pay(pp[g+1])
    );
  end

  assign neg_q     = pp[N][0];
  assign out_valid = vv[N];
  assign cos_q30   = neg_q ? -rot[N].x : rot[N].x;
  assign sin_q30   = neg_q ? -rot[N].y : rot[N].y;
  assign out_pay   = pp[N];
endmodule
`default_nettype wire

// ===== sv/afcp_mix.sv =====
// Torque rotation, axial term and six-chamber combine, saturation.
`timescale 1ns / 1ps
`default_nettype none
module afcp_mix
  import afcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  input  wire logic signed [XW-1:0] cos_q30,
  input  wire logic signed [XW-1:0] sin_q30,
  input  wire logic signed [15:0] alpha,
  input  wire logic [15:0]        len,
  input  wire logic [3:0]         tag,
  output logic                    out_valid,
  output logic [3:0]              out_tag,
  output logic signed [31:0]      pr [6]
);
  // stage A: torques, length difference (inputs are registered already)
  logic signed [33:0] tx_a, ty_a;
  logic signed [17:0] dl_a;
  logic signed [XW-1:0] cs_a, sn_a;
  logic signed [15:0] t_alpha;
  logic [3:0] tag_a, tag_b, tag_c, tag_d;
  logic va, vb, vc, vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0;
    end else if (en) begin
      va <= in_valid; vb <= va; vc <= vb; vd <= vc;
    end
  end

  assign t_alpha = alpha;
  always_ff @(posedge clk) begin
    if (en) begin
      tx_a <= (34'(cfg.torque_a) <<< 12) - 34'($signed({1'b0, cfg.bend_stiffness}) * t_alpha);
      ty_a <= 34'(cfg.torque_b) <<< 12;
      dl_a <= $signed({2'b0, len}) - $signed({2'b0, cfg.rest_length});
      cs_a <= cos_q30;
      sn_a <= sin_q30;
      tag_a <= tag;
    end
  end

  // stage B: four products and axial product
  logic signed [67:0] cx_b, sy_b, sx_b, cy_b;
  logic signed [35:0] ax_b;
  always_ff @(posedge clk) begin
    if (en) begin
      cx_b <= 68'(cs_a) * 68'(tx_a);
      sy_b <= 68'(sn_a) * 68'(ty_a);
      sx_b <= 68'(sn_a) * 68'(tx_a);
      cy_b <= 68'(cs_a) * 68'(ty_a);
      ax_b <= 36'($signed({1'b0, cfg.axial_stiffness}) * dl_a);
      tag_b <= tag_a;
    end
  end

  // stage C: c, s rounding; p
  logic signed [67:0] cv, sv;
  logic signed [42:0] c_c, s_c;
  logic signed [53:0] p_c;
  always_comb begin
    cv = (cx_b - sy_b + (68'sd1 <<< 25)) >>> 26;
    sv = (sx_b + cy_b + (68'sd1 <<< 25)) >>> 26;
  end
  logic signed [63:0] ks_full;
  always_ff @(posedge clk) begin
    if (en) begin
      c_c <= 43'(cv);
      s_c <= 43'(sv);
      p_c <= (54'(ax_b) + 54'(cfg.axial_force)) <<< 16;
      tag_c <= tag_b;
    end
  end

  // stage D: sqrt3*s rounding and numerators
  logic signed [55:0] n_d [6];
  logic signed [55:0] ks, c1, c2, pp;
  always_comb begin
    ks_full = 64'(s_c) * 64'(SQRT3_Q16);
    ks = 56'((ks_full + (64'sd1 <<< 15)) >>> 16);
    c1 = 56'(c_c);
    c2 = c1 <<< 1;
    pp = 56'(p_c);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_d[0] <= pp + c2;
      n_d[1] <= pp + c1 + ks;
      n_d[2] <= pp - c1 + ks;
      n_d[3] <= pp - c2;
      n_d[4] <= pp - c1 - ks;
      n_d[5] <= pp + c1 - ks;
      tag_d <= tag_c;
    end
  end

  // stage E: divide by 6*2^16 (shift by 17, divide by 3), offset, saturate
  // shifted numerator stays within 34 bits signed
  localparam logic signed [34:0] RECIP3 = 35'sd11453246123; // ceil(2^35/3)
  logic signed [38:0] q_e [6];
  logic signed [33:0] qv, r;
  logic signed [68:0] prod;
  logic signed [40:0] v;
  logic signed [55:0] t;
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      t = (n_d[k] + 56'sd196608) >>> 17;   // floor(N+3*2^16)/2^17
      qv = 34'(t);
      prod = 69'(qv) * 69'(RECIP3);
      r = 34'(prod >>> 35);                 // floor(qv/3) up to one low
      if (qv - r * 34'sd3 >= 34'sd3) r = r + 34'sd1;
      q_e[k] = 39'(r);
    end
  end
  logic signed [38:0] q_r [6];
  logic [3:0] tag_e;
  logic ve;
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else if (en) ve <= vd;
    if (en) begin
      q_r <= q_e;
      tag_e <= tag_d;
    end
  end
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (k % 2 == 0) v = 41'(q_r[k]) - 41'(cfg.pressure_offset);
      else v = 41'(q_r[k]) + 41'(cfg.pressure_offset);
      if (v > 41'sd2147483647) pr[k] = 32'sh7fffffff;
      else if (v < -41'sd2147483648) pr[k] = 32'sh80000000;
      else pr[k] = 32'(v);
    end
  end
  assign out_valid = ve;
  assign out_tag = tag_e;
endmodule
`default_nettype wire

// ===== sv/abl_feedforward_chamber_pressure_top.sv =====
// Top level of the feed-forward chamber pressure pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Maps each segment setpoint (bend angle, bend direction, length) to six
// chamber pressures. Fully pipelined: one item per cycle while the sink takes
// items; it has one register per CORDIC rotation plus the reduction, torque,
// product, rounding, numerator and divide stages.
// Every stage advances together under one enable; a stalled sink freezes
// the whole line, and the output register holds its item until taken.
// Configuration is written through cfg_we/cfg_index/cfg_data and must be
// stable while items are in flight. SEGMENTS only documents the expected
// tag range; tags pass through unchanged.
module abl_feedforward_chamber_pressure_top
  import afcp_pkg::*;
#(
  parameter int SEGMENTS = 9,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  afcp_setpoint_if.sink    setpoint,
  afcp_pressure_if.source  pressure
);
  localparam int PW = 1 + 4 + 16 + 16;  // neg flag, tag, alpha, length

  cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BEND_STIFF:  cfg.bend_stiffness  <= cfg_data;
        CFG_AXIAL_STIFF: cfg.axial_stiffness <= cfg_data;
        CFG_REST_LEN:    cfg.rest_length     <= cfg_data;
        CFG_AXIAL_FORCE: cfg.axial_force     <= cfg_data;
        CFG_TORQUE_A:    cfg.torque_a        <= cfg_data;
        CFG_TORQUE_B:    cfg.torque_b        <= cfg_data;
        CFG_OFFSET:      cfg.pressure_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole line moves when the output slot is free or being taken
  logic en;
  assign en = !pressure.valid || pressure.ready;
  assign setpoint.ready = en;

  logic in_v;
  assign in_v = setpoint.valid && en;

  logic                 sc_v;
  logic signed [XW-1:0] cs, sn;
  logic [PW-1:0]        pay;

  afcp_sincos #(.ITER(TRIG_ITERATIONS), .PW(PW)) u_sincos (
    .clk, .rst, .en,
    .in_valid(in_v),
    .beta(setpoint.bend_direction),
    .in_pay({setpoint.segment_index, setpoint.bend_angle, setpoint.seg_length, 1'b0}),
    .out_valid(sc_v), .cos_q30(cs), .sin_q30(sn), .out_pay(pay)
  );

  logic signed [31:0] pr [6];
  afcp_mix u_mix (
    .clk, .rst, .en, .cfg,
    .in_valid(sc_v), .cos_q30(cs), .sin_q30(sn),
    .alpha(pay[32:17]), .len(pay[16:1]), .tag(pay[36:33]),
    .out_valid(pressure.valid), .out_tag(pressure.segment_tag), .pr(pr)
  );

  assign pressure.pressure_0 = pr[0];
  assign pressure.pressure_1 = pr[1];
  assign pressure.pressure_2 = pr[2];
  assign pressure.pressure_3 = pr[3];
  assign pressure.pressure_4 = pr[4];
  assign pressure.pressure_5 = pr[5];
endmodule
`default_nettype wire

// ===== sv/afcp_checker.sv =====
// Port-level checker for the chamber pressure top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module afcp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] p0,
  input wire logic [31:0] p3
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(p0) && $stable(p3))
    else $error("stalled item changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted during stall");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind abl_feedforward_chamber_pressure_top afcp_checker u_afcp_checker (
  .clk(clk), .rst(rst),
  .in_valid(setpoint.valid), .in_ready(setpoint.ready),
  .out_valid(pressure.valid), .out_ready(pressure.ready),
  .p0(pressure.pressure_0), .p3(pressure.pressure_3)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the chamber pressure pipeline: random and directed setpoints checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import afcp_pkg::*;

  // Same values as the DUT defaults.
  localparam int SEGMENTS        = 9;
  localparam int TRIG_ITERATIONS = 16;
  localparam int PIPE_LATENCY    = TRIG_ITERATIONS + 6;
  localparam int CYCLE_LIMIT     = 400000;
  // Unused register slot: a write there must change nothing.
  localparam logic [2:0] CFG_NONE = 3'd7;

  // Q3.12 angle landmarks
  localparam logic signed [15:0] ANG_PI      = 16'sd12868;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd6434;

  typedef struct {
    logic [3:0]         seg;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        len;
  } setpoint_t;

  typedef struct {
    logic [3:0]                seg;
    logic signed [5:0][31:0]   p;
  } chambers_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  afcp_setpoint_if sp ();
  afcp_pressure_if pr ();

  abl_feedforward_chamber_pressure_top #(
    .SEGMENTS(SEGMENTS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .setpoint(sp.sink),
    .pressure(pr.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arctangent table in Q.30, truncated
  longint atan_tbl [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127};

  cfg_t       regs_shadow;           // what the DUT registers should hold
  setpoint_t  setpoint_q[$];         // items waiting for the driver
  chambers_t  pressure_expect_q[$];  // predicted results, oldest first
  int         errors = 0;
  int         sent_cnt = 0;
  bit         idle_en = 1'b1;        // random gaps on both sides
  longint     cycles = 0;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Round the Q.16 numerator over six, apply offset, saturate.
  function automatic logic [31:0] chamber_value(longint num, longint off);
    longint v;
    longint d;
    d = 6 * 65536;
    v = num + 3 * 65536;
    v = (v >= 0) ? v / d : -((-v + d - 1) / d);
    v = v + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic chambers_t chamber_pressures(setpoint_t it, cfg_t r);
    chambers_t res;
    longint z, x, y, nx, sn, cs, tx, ty, c, s, ks, p, off;
    bit neg;
    int n;
    z = longint'(it.beta) * 262144;
    x = 652032874;
    y = 0;
    neg = 1'b0;
    while (z > 64'sd3373259426) z -= 64'sd6746518852;
    while (z < -64'sd3373259426) z += 64'sd6746518852;
    // fold into [-pi/2, pi/2]; both sin and cos flip sign
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      neg = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      neg = 1'b1;
    end
    n = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_tbl[i];
      end
      x = nx;
    end
    cs = neg ? -x : x;
    sn = neg ? -y : y;
    tx = longint'(r.torque_a) * 4096 - longint'({1'b0, r.bend_stiffness}) * longint'(it.alpha);
    ty = longint'(r.torque_b) * 4096;
    c  = rnd_shift(cs * tx - sn * ty, 26);
    s  = rnd_shift(sn * tx + cs * ty, 26);
    ks = rnd_shift(113512 * s, 16);
    p  = (longint'(r.axial_force) + longint'({1'b0, r.axial_stiffness}) *
          (longint'({1'b0, it.len}) - longint'({1'b0, r.rest_length}))) * 65536;
    off = longint'(r.pressure_offset);
    res.seg  = it.seg;
    res.p[0] = chamber_value(p + 2 * c, -off);
    res.p[1] = chamber_value(p + c + ks, off);
    res.p[2] = chamber_value(p - c + ks, -off);
    res.p[3] = chamber_value(p - 2 * c, off);
    res.p[4] = chamber_value(p - c - ks, -off);
    res.p[5] = chamber_value(p + c - ks, off);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued items, predicts each one as it is accepted.
  // ---------------------------------------------------------------------
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      sp.valid <= 1'b0;
    end else if (!sp.valid || sp.ready) begin
      if (sp.valid) begin
        setpoint_t acc;
        acc.seg   = sp.segment_index;
        acc.alpha = sp.bend_angle;
        acc.beta  = sp.bend_direction;
        acc.len   = sp.seg_length;
        pressure_expect_q.push_back(chamber_pressures(acc, regs_shadow));
        sent_cnt++;
      end
      if (send_gap > 0) begin
        send_gap--;
        sp.valid <= 1'b0;
      end else if (setpoint_q.size() > 0) begin
        setpoint_t nxt;
        nxt = setpoint_q.pop_front();
        sp.segment_index  <= nxt.seg;
        sp.bend_angle     <= nxt.alpha;
        sp.bend_direction <= nxt.beta;
        sp.seg_length     <= nxt.len;
        sp.valid          <= 1'b1;
        send_gap = pick_gap();
      end else begin
        sp.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every taken item, drives ready with random stalls.
  // One long hold-off after a few hundred items fills the pipeline so
  // that it must push back on the setpoint side.
  // ---------------------------------------------------------------------
  int  hold_cnt = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      pr.ready <= 1'b0;
    end else begin
      if (pr.valid && pr.ready) begin
        chambers_t got;
        chambers_t want;
        got.seg  = pr.segment_tag;
        got.p[0] = pr.pressure_0;
        got.p[1] = pr.pressure_1;
        got.p[2] = pr.pressure_2;
        got.p[3] = pr.pressure_3;
        got.p[4] = pr.pressure_4;
        got.p[5] = pr.pressure_5;
        if (pressure_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: tag %0d", got.seg);
        end else begin
          want = pressure_expect_q.pop_front();
          if (got.seg !== want.seg) begin
            errors++;
            if (errors <= 10)
              $display("segment_tag: expected %0d got %0d", want.seg, got.seg);
          end
          for (int k = 0; k < 6; k++) begin
            if (got.p[k] !== want.p[k]) begin
              errors++;
              if (errors <= 10)
                $display("pressure_%0d (tag %0d): expected %0d got %0d",
                         k, want.seg, want.p[k], got.p[k]);
            end
          end
        end
      end
      if (!long_hold_done && sent_cnt >= 300) begin
        long_hold_done = 1'b1;
        hold_cnt = 200;
        pr.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        pr.ready <= 1'b0;
      end else begin
        hold_cnt = pick_gap();
        pr.ready <= (hold_cnt == 0);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("abl_feedforward_chamber_pressure_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_BEND_STIFF:  regs_shadow.bend_stiffness  = val;
      CFG_AXIAL_STIFF: regs_shadow.axial_stiffness = val;
      CFG_REST_LEN:    regs_shadow.rest_length     = val;
      CFG_AXIAL_FORCE: regs_shadow.axial_force     = val;
      CFG_TORQUE_A:    regs_shadow.torque_a        = val;
      CFG_TORQUE_B:    regs_shadow.torque_b        = val;
      CFG_OFFSET:      regs_shadow.pressure_offset = val;
      default: ;  // unused slot, ignored
    endcase
  endtask

  // Registers in list order; closes the write burst.
  task automatic cfg_all(logic [15:0] bs, logic [15:0] as, logic [15:0] rl,
                         logic [15:0] af, logic [15:0] ta, logic [15:0] tb,
                         logic [15:0] po);
    cfg_write(CFG_BEND_STIFF, bs);
    cfg_write(CFG_AXIAL_STIFF, as);
    cfg_write(CFG_REST_LEN, rl);
    cfg_write(CFG_AXIAL_FORCE, af);
    cfg_write(CFG_TORQUE_A, ta);
    cfg_write(CFG_TORQUE_B, tb);
    cfg_write(CFG_OFFSET, po);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until the pipeline has drained completely.
  task automatic drain();
    while (setpoint_q.size() != 0 || sp.valid || pressure_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_sp(logic [3:0] seg, logic signed [15:0] a,
                         logic signed [15:0] b, logic [15:0] len);
    setpoint_t it;
    it.seg = seg; it.alpha = a; it.beta = b; it.len = len;
    setpoint_q.push_back(it);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++)
      push_sp(4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Field extremes, angle wrap and fold boundaries, tags past SEGMENTS,
  // length on both sides of rest length.
  task automatic push_directed();
    push_sp(4'd0, 16'sd0, 16'sd0, 16'd0);
    push_sp(4'd15, 16'sh7fff, 16'sh7fff, 16'hffff);
    push_sp(4'd8, -16'sd32768, -16'sd32768, 16'h0000);
    push_sp(4'd9, 16'sd4096, ANG_PI, 16'd1000);
    push_sp(4'd1, -16'sd4096, -ANG_PI, 16'd1000);
    push_sp(4'd2, 16'sd100, ANG_PI + 16'sd1, 16'h8000);
    push_sp(4'd3, -16'sd100, -ANG_PI - 16'sd1, 16'h7fff);
    push_sp(4'd4, 16'sd2048, ANG_HALF_PI, 16'd1);
    push_sp(4'd5, 16'sd2048, ANG_HALF_PI + 16'sd1, 16'd2);
    push_sp(4'd6, -16'sd2048, -ANG_HALF_PI, 16'd3);
    push_sp(4'd7, -16'sd2048, -ANG_HALF_PI - 16'sd1, 16'h5555);
    push_sp(4'd10, 16'sh5555, 16'shaaaa, 16'haaaa);
    push_sp(4'd12, 16'shaaaa, 16'sh5555, 16'h5555);
    push_sp(4'd14, 16'sd1, -16'sd1, 16'hfffe);
  endtask

  initial begin
    sp.valid = 1'b0;
    sp.segment_index = '0;
    sp.bend_angle = '0;
    sp.bend_direction = '0;
    sp.seg_length = '0;
    pr.ready = 1'b0;
    regs_shadow = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values
    push_directed();
    push_random(40);
    drain();

    // Everything at its top end but the rest length, which is zero
    cfg_all(16'hffff, 16'hffff, 16'h0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_directed();
    push_random(100);
    drain();

    // Negative extremes, large rest length
    cfg_all(16'hffff, 16'hffff, 16'hffff, -16'sd32768, -16'sd32768, -16'sd32768,
            -16'sd32768);
    cfg_write(CFG_NONE, 16'hffff);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_directed();
    push_random(100);
    drain();

    // Random settings; one phase runs with no idling at all
    for (int ph = 0; ph < 5; ph++) begin
      idle_en = (ph != 2);
      cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
      push_random(150);
      drain();
    end
    idle_en = 1'b1;

    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (pressure_expect_q.size() != 0) begin
      errors++;
      $display("%0d predicted items never came out", pressure_expect_q.size());
    end
    if (errors == 0)
      $display("abl_feedforward_chamber_pressure_top verification clean");
    else
      $display("abl_feedforward_chamber_pressure_top verification failed");
    $finish;
  end

endmodule
`default_nettype wire
